// ===== rtl/gha_pkg.sv =====
// shared types and constants of the generational handle allocator
// no dependencies; used by the allocator top level

package gha_pkg;

	localparam int unsigned MAX_SLOTS = 1024;
	localparam int unsigned IDX_W     = 10;   // slot index width
	localparam int unsigned GEN_W     = 32;   // generation width
	localparam int unsigned CNT_W     = 11;   // counts up to MAX_SLOTS

	// generation store entry: live bit above the generation
	localparam int unsigned ENT_W = GEN_W + 1;
	// recycle stack entry: generation above the slot index
	localparam int unsigned STK_W = GEN_W + IDX_W;

	localparam int unsigned IN_DATA_W  = 48;  // index + generation, byte aligned
	localparam int unsigned OUT_DATA_W = 56;  // index, generation, live, total

	typedef enum logic [1:0] {
		CMD_CREATE  = 2'd0,
		CMD_DESTROY = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_NO_FREE = 2'd1,
		STS_STALE   = 2'd2,
		STS_RANGE   = 2'd3
	} status_t;

endpackage

// ===== rtl/gha_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used for the generation store and the recycle stack

module gha_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/generational_handle_allocator.sv =====
// generational handle allocator: an item is taken only after the previous one has executed, result registered
// the input transfer launches the registered read of the generation and stack rams;
// the execute state then loads the result into the output register once it is free
// the next item is taken while an earlier result still waits on the master side
// reset: a clearing pass zeroes all 1024 generation store entries, s_tready stays low meanwhile
// depends on gha_pkg and gha_ram

module generational_handle_allocator (
	input  logic        clk,
	input  logic        arst_n,

	// configuration: active_capacity
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,

	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // handle_index[9:0], handle_generation[41:10], zero pad
	input  logic [1:0]  s_tuser,   // command[1:0]

	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // given_index[9:0], given_generation[41:10],
	                               // is_live[42], live_total[53:43], zero pad
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int unsigned IDX_W = gha_pkg::IDX_W;
	localparam int unsigned GEN_W = gha_pkg::GEN_W;
	localparam int unsigned CNT_W = gha_pkg::CNT_W;
	localparam int unsigned ENT_W = gha_pkg::ENT_W;
	localparam int unsigned STK_W = gha_pkg::STK_W;
	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(gha_pkg::MAX_SLOTS);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// control and counters
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] depth_q;     // recycle stack fill
	logic [CNT_W-1:0] fresh_q;     // next never-used slot
	logic [CNT_W-1:0] live_cnt_q;
	logic [IDX_W-1:0] clr_idx_q;

	// item held for the execute cycle
	gha_pkg::cmd_t    cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [GEN_W-1:0] gen_q;

	// output register
	logic                           m_tvalid_q;
	logic [gha_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]                     m_tuser_q;

	// ram ports
	logic             gen_we, gen_re;
	logic [IDX_W-1:0] gen_waddr;
	logic [ENT_W-1:0] gen_wdata, gen_rdata;
	logic             stk_we, stk_re;
	logic [IDX_W-1:0] stk_raddr;
	logic [STK_W-1:0] stk_wdata, stk_rdata;

	logic s_xfer, out_free, fire;
	logic [CNT_W-1:0] cap_eff, depth_dec;

	// execute results
	gha_pkg::status_t ex_status;
	logic [IDX_W-1:0] ex_idx;
	logic [GEN_W-1:0] ex_gen;
	logic             ex_live;
	logic [CNT_W-1:0] nxt_depth, nxt_fresh, nxt_live;
	logic             ex_gen_we, ex_stk_we;
	logic [ENT_W-1:0] ex_gen_wdata;
	logic             rd_live;
	logic [GEN_W-1:0] rd_gen, bumped_gen;

	// capacity clamped to 1..MAX_SLOTS
	always_comb begin
		priority if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap_q > CAP_MAX) begin
			cap_eff = CAP_MAX;
		end else begin
			cap_eff = cap_q;
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign fire      = (state_q == ST_EXEC) && out_free;

	// reads are launched with the transfer; data stays put until the next one
	assign gen_re    = s_xfer;
	assign stk_re    = s_xfer;
	assign depth_dec = depth_q - CNT_W'(1);
	assign stk_raddr = depth_dec[IDX_W-1:0];

	assign rd_live    = gen_rdata[GEN_W];
	assign rd_gen     = gen_rdata[GEN_W-1:0];
	assign bumped_gen = rd_gen + GEN_W'(1);   // wraps at 32 bits

	// execute: decide the result and the state updates
	always_comb begin
		ex_status    = gha_pkg::STS_OK;
		ex_idx       = '0;
		ex_gen       = '0;
		ex_live      = 1'b0;
		nxt_depth    = depth_q;
		nxt_fresh    = fresh_q;
		nxt_live     = live_cnt_q;
		ex_gen_we    = 1'b0;
		ex_stk_we    = 1'b0;
		ex_gen_wdata = '0;
		unique case (cmd_q)
			gha_pkg::CMD_CREATE: begin
				if (depth_q != '0) begin
					// recycled slot: its generation travels with it on the stack
					ex_idx       = stk_rdata[IDX_W-1:0];
					ex_gen       = stk_rdata[STK_W-1:IDX_W];
					nxt_depth    = depth_dec;
					nxt_live     = live_cnt_q + CNT_W'(1);
					ex_gen_we    = 1'b1;
					ex_gen_wdata = {1'b1, ex_gen};
				end else if (fresh_q < cap_eff) begin
					// a never-used slot still has generation zero
					ex_idx       = fresh_q[IDX_W-1:0];
					nxt_fresh    = fresh_q + CNT_W'(1);
					nxt_live     = live_cnt_q + CNT_W'(1);
					ex_gen_we    = 1'b1;
					ex_gen_wdata = {1'b1, {GEN_W{1'b0}}};
				end else begin
					ex_status = gha_pkg::STS_NO_FREE;
				end
			end
			gha_pkg::CMD_DESTROY, gha_pkg::CMD_QUERY: begin
				if ({1'b0, idx_q} >= cap_eff) begin
					ex_status = gha_pkg::STS_RANGE;
				end else if (!(rd_live && (rd_gen == gen_q))) begin
					ex_status = gha_pkg::STS_STALE;
				end else if (cmd_q == gha_pkg::CMD_QUERY) begin
					ex_live = 1'b1;
				end else begin
					ex_gen_we    = 1'b1;
					ex_gen_wdata = {1'b0, bumped_gen};
					if (depth_q < CAP_MAX) begin
						ex_stk_we = 1'b1;
						nxt_depth = depth_q + CNT_W'(1);
					end
					if (live_cnt_q != '0) begin
						nxt_live = live_cnt_q - CNT_W'(1);
					end
				end
			end
			default: begin
				// unused command: no change
			end
		endcase
	end

	// generation store write port is shared by the clearing pass
	always_comb begin
		if (state_q == ST_CLEAR) begin
			gen_we    = 1'b1;
			gen_waddr = clr_idx_q;
			gen_wdata = '0;
		end else begin
			gen_we    = fire && ex_gen_we;
			gen_waddr = (cmd_q == gha_pkg::CMD_CREATE) ? ex_idx : idx_q;
			gen_wdata = ex_gen_wdata;
		end
	end

	assign stk_we    = fire && ex_stk_we;
	assign stk_wdata = {bumped_gen, idx_q};

	gha_ram #(
		.WIDTH (gha_pkg::ENT_W),
		.DEPTH (gha_pkg::MAX_SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (s_tdata[IDX_W-1:0]),
		.rdata (gen_rdata)
	);

	gha_ram #(
		.WIDTH (gha_pkg::STK_W),
		.DEPTH (gha_pkg::MAX_SLOTS)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[IDX_W-1:0]),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// state, counters and the registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cap_q      <= CAP_MAX;
			depth_q    <= '0;
			fresh_q    <= '0;
			live_cnt_q <= '0;
			clr_idx_q  <= '0;
			cmd_q      <= gha_pkg::CMD_CREATE;
			idx_q      <= '0;
			gen_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			// a new result replaces the one taken at this edge
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == {IDX_W{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						cmd_q   <= gha_pkg::cmd_t'(s_tuser);
						idx_q   <= s_tdata[IDX_W-1:0];
						gen_q   <= s_tdata[IDX_W+GEN_W-1:IDX_W];
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					// wait here while the previous result is still unclaimed
					if (out_free) begin
						depth_q    <= nxt_depth;
						fresh_q    <= nxt_fresh;
						live_cnt_q <= nxt_live;
						m_tuser_q  <= ex_status;
						m_tdata_q  <= {2'b00, nxt_live, ex_live, ex_gen, ex_idx};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// every slot handed out so far is either live or waiting on the stack
	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(live_cnt_q + depth_q) == fresh_q)
		else $error("live count and stack fill do not add up to slots used");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= CAP_MAX)
		else $error("fresh slot pointer beyond pool");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q) == ST_EXEC)
		else $error("result appeared without an execute cycle");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !(m_tvalid_q && !$past(m_tvalid_q)))
		else $error("result produced during clearing pass");

endmodule
